// ----- design/lei_pkg.sv -----
// Shared constants and saturating helpers for the Lorenz Euler integrator.
// No dependencies.
package lei_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int MAX_POINTS_DEF = 65536;
   localparam logic [16:0] COUNT_RESET = 17'd50000;

   // csr register indexes
   localparam logic [2:0] REG_SIGMA = 3'd0;
   localparam logic [2:0] REG_RHO = 3'd1;
   localparam logic [2:0] REG_BETA = 3'd2;
   localparam logic [2:0] REG_STEP_SIZE = 3'd3;
   localparam logic [2:0] REG_START_X = 3'd4;
   localparam logic [2:0] REG_START_Y = 3'd5;
   localparam logic [2:0] REG_START_Z = 3'd6;
   localparam logic [2:0] REG_POINT_COUNT = 3'd7;

   localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
      if (s[32] != s[31]) begin
         return s[32] ? SAT_MIN : SAT_MAX;
      end
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      return sat33(s);
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) - 33'(b);
      return sat33(s);
   endfunction

endpackage

// ----- design/lei_fxmul.sv -----
// Shared fixed-point multiplier: registered 32x32 signed product, then floor
// shift by the fraction width and saturation to 32 bits. Uses lei_pkg.
module lei_fxmul #(
   parameter int FRAC_BITS = lei_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [31:0] result
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [63:0] shifted;

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic shift is a floor toward minus infinity
   assign shifted = prod_ff >>> FRAC_BITS;

   always_comb begin
      if ((&shifted[63:31]) || !(|shifted[63:31])) begin
         result = shifted[31:0];
      end else begin
         result = shifted[63] ? lei_pkg::SAT_MIN : lei_pkg::SAT_MAX;
      end
   end

endmodule

// ----- design/lorenz_euler_integrator.sv -----
// Lorenz attractor point generator, forward Euler in signed fixed point.
// A restart or wrap request loads the start point as its result; an advancing
// request first runs 8 sequencer steps through the one shared multiplier, then
// the result load. The result load waits while the output is stalled, and a new
// request is taken only once the previous result is loaded. Synchronous reset loads
// the default coefficients and start point; the first request loads the start.
module lorenz_euler_integrator #(
   parameter int FRAC_BITS = lei_pkg::FRAC_BITS_DEF,
   parameter int MAX_POINTS = lei_pkg::MAX_POINTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic [15:0]        rsp_point_index,
   output logic [7:0]         rsp_color_red,
   output logic [6:0]         rsp_color_green,
   output logic [5:0]         rsp_color_blue,
   output logic               rsp_is_last
);

   localparam longint One = longint'(1) << FRAC_BITS;
   localparam logic signed [31:0] SigmaReset = 32'(longint'(10) * One);
   localparam logic signed [31:0] RhoReset = 32'(longint'(28) * One);
   localparam logic signed [31:0] BetaReset = 32'((longint'(16) * One + 3) / 6);
   localparam logic [30:0] DtReset = 31'((One + 50) / 100);
   localparam int CountCap = (MAX_POINTS < 65536) ? MAX_POINTS : 65536;
   localparam logic [16:0] CountLimit = 17'(CountCap);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // sequencer steps: issue at step s, capture the product at step s+1
   localparam logic [2:0] SQ_DTS = 3'd0;
   localparam logic [2:0] SQ_XRZ = 3'd1;
   localparam logic [2:0] SQ_XY = 3'd2;
   localparam logic [2:0] SQ_BZ = 3'd3;
   localparam logic [2:0] SQ_NX = 3'd4;
   localparam logic [2:0] SQ_NY = 3'd5;
   localparam logic [2:0] SQ_NZ = 3'd6;
   localparam logic [2:0] SQ_END = 3'd7;

   logic signed [31:0] sigma_ff, rho_ff, beta_ff;
   logic [30:0]        step_size_ff;
   logic signed [31:0] start_x_ff, start_y_ff, start_z_ff;
   logic [16:0]        point_count_ff;

   logic [1:0]         state_ff;
   logic [2:0]         step_ff;
   logic               load_ff;
   logic [16:0]        count_ff;
   logic               run_started_ff;
   logic signed [31:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic [15:0]        cur_index_ff;

   logic signed [31:0] dts_ff, xrz_ff, xy_ff, bz_ff, nx_ff, ny_ff, nz_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [15:0]        rsp_index_ff;
   logic               rsp_last_ff;

   logic signed [31:0] dt_ext;
   logic signed [31:0] op_a, op_b, mul_res;
   logic [16:0]        count_min, eff_count;
   logic               req_fire, load_in, out_free;
   logic [15:0]        index_in;
   logic signed [31:0] x_in, y_in, z_in;

   assign dt_ext = {1'b0, step_size_ff};

   always_comb begin
      count_min = (point_count_ff == 17'd0) ? 17'd1 : point_count_ff;
      eff_count = (count_min > CountLimit) ? CountLimit : count_min;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire = req_valid && !req_stall;
   assign load_in = req_restart || !run_started_ff ||
                    (({1'b0, cur_index_ff} + 17'd1) >= eff_count);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (step_ff)
         SQ_DTS: begin
            op_a = dt_ext;
            op_b = sigma_ff;
         end
         SQ_XRZ: begin
            op_a = cur_x_ff;
            op_b = lei_pkg::sat_sub(rho_ff, cur_z_ff);
         end
         SQ_XY: begin
            op_a = cur_x_ff;
            op_b = cur_y_ff;
         end
         SQ_BZ: begin
            op_a = beta_ff;
            op_b = cur_z_ff;
         end
         SQ_NX: begin
            op_a = dts_ff;
            op_b = lei_pkg::sat_sub(cur_y_ff, cur_x_ff);
         end
         SQ_NY: begin
            op_a = dt_ext;
            op_b = lei_pkg::sat_sub(xrz_ff, cur_y_ff);
         end
         SQ_NZ: begin
            op_a = dt_ext;
            op_b = lei_pkg::sat_sub(xy_ff, bz_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   lei_fxmul #(.FRAC_BITS(FRAC_BITS)) u_fxmul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .result(mul_res)
   );

   always_ff @(posedge clock) begin
      if (state_ff == ST_CALC) begin
         case (step_ff)
            SQ_XRZ: dts_ff <= mul_res;
            SQ_XY:  xrz_ff <= mul_res;
            SQ_BZ:  xy_ff <= mul_res;
            SQ_NX:  bz_ff <= mul_res;
            SQ_NY:  nx_ff <= lei_pkg::sat_add(cur_x_ff, mul_res);
            SQ_NZ:  ny_ff <= lei_pkg::sat_add(cur_y_ff, mul_res);
            SQ_END: nz_ff <= lei_pkg::sat_add(cur_z_ff, mul_res);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (load_ff) begin
         x_in = start_x_ff;
         y_in = start_y_ff;
         z_in = start_z_ff;
         index_in = '0;
      end else begin
         x_in = nx_ff;
         y_in = ny_ff;
         z_in = nz_ff;
         index_in = cur_index_ff + 16'd1;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff <= SigmaReset;
         rho_ff <= RhoReset;
         beta_ff <= BetaReset;
         step_size_ff <= DtReset;
         start_x_ff <= 32'(DtReset);
         start_y_ff <= '0;
         start_z_ff <= '0;
         point_count_ff <= lei_pkg::COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lei_pkg::REG_SIGMA:       sigma_ff <= csr_wdata;
            lei_pkg::REG_RHO:         rho_ff <= csr_wdata;
            lei_pkg::REG_BETA:        beta_ff <= csr_wdata;
            lei_pkg::REG_STEP_SIZE:   step_size_ff <= csr_wdata[30:0];
            lei_pkg::REG_START_X:     start_x_ff <= csr_wdata;
            lei_pkg::REG_START_Y:     start_y_ff <= csr_wdata;
            lei_pkg::REG_START_Z:     start_z_ff <= csr_wdata;
            lei_pkg::REG_POINT_COUNT: point_count_ff <= csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer and trajectory state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= SQ_DTS;
         load_ff <= 1'b0;
         count_ff <= lei_pkg::COUNT_RESET;
         run_started_ff <= 1'b0;
         cur_x_ff <= 32'(DtReset);
         cur_y_ff <= '0;
         cur_z_ff <= '0;
         cur_index_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a result loaded in ST_DONE replaces the one taken this cycle
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  load_ff <= load_in;
                  count_ff <= eff_count;
                  step_ff <= SQ_DTS;
                  state_ff <= load_in ? ST_DONE : ST_CALC;
               end
            end
            ST_CALC: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == SQ_END) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  cur_x_ff <= x_in;
                  cur_y_ff <= y_in;
                  cur_z_ff <= z_in;
                  cur_index_ff <= index_in;
                  run_started_ff <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_x_ff <= x_in;
         rsp_y_ff <= y_in;
         rsp_z_ff <= z_in;
         rsp_index_ff <= index_in;
         rsp_last_ff <= (({1'b0, index_in} + 17'd1) == count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rsp_x_ff;
   assign rsp_pos_y = rsp_y_ff;
   assign rsp_pos_z = rsp_z_ff;
   assign rsp_point_index = rsp_index_ff;
   assign rsp_color_red = rsp_index_ff[7:0];
   assign rsp_color_green = rsp_index_ff[6:0];
   assign rsp_color_blue = rsp_index_ff[5:0];
   assign rsp_is_last = rsp_last_ff;

endmodule

// ----- sim/tb_lorenz_euler_integrator.sv -----
// Testbench for lorenz_euler_integrator: drives restart and advance requests under many
// register settings, predicts each Q16.16 trajectory point and checks every response field.
// Depends on design/lei_pkg.sv and design/lorenz_euler_integrator.sv.

typedef struct packed {
   logic [31:0] pos_x;
   logic [31:0] pos_y;
   logic [31:0] pos_z;
   logic [15:0] point_index;
   logic [7:0]  red;
   logic [6:0]  green;
   logic [5:0]  blue;
   logic        is_last;
} lorenz_point_type;

// Tracks the integrator state and the points it still owes.
class lorenz_tracker;
   logic signed [31:0] sigma, rho, beta, start_x, start_y, start_z;
   logic [30:0]        step_size;
   logic [16:0]        point_count;
   logic signed [31:0] cur_x, cur_y, cur_z;
   logic [15:0]        cur_index;
   bit                 run_started;
   lorenz_point_type   expected_points[$];
   int accepted, checked, restarts, wraps, last_points, reg_writes, errors;

   function new();
      sigma = 32'sd655360;
      rho = 32'sd1835008;
      beta = 32'sd174763;
      step_size = 31'd655;
      start_x = 32'sd655;
      start_y = '0;
      start_z = '0;
      point_count = lei_pkg::COUNT_RESET;
      cur_x = start_x;
      cur_y = start_y;
      cur_z = start_z;
      cur_index = '0;
      run_started = 0;
   endfunction

   function logic signed [31:0] clamp32(longint v);
      if (v > longint'(lei_pkg::SAT_MAX)) return lei_pkg::SAT_MAX;
      if (v < longint'(lei_pkg::SAT_MIN)) return lei_pkg::SAT_MIN;
      return v[31:0];
   endfunction

   // exact product, floor shift, then clamp
   function logic signed [31:0] qmul(longint a, longint b);
      return clamp32((a * b) >>> lei_pkg::FRAC_BITS_DEF);
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] value);
      reg_writes++;
      case (idx)
         lei_pkg::REG_SIGMA:       sigma = value;
         lei_pkg::REG_RHO:         rho = value;
         lei_pkg::REG_BETA:        beta = value;
         lei_pkg::REG_STEP_SIZE:   step_size = value[30:0];
         lei_pkg::REG_START_X:     start_x = value;
         lei_pkg::REG_START_Y:     start_y = value;
         lei_pkg::REG_START_Z:     start_z = value;
         lei_pkg::REG_POINT_COUNT: point_count = value[16:0];
         default: ;
      endcase
   endfunction

   function void note_request(bit restart);
      int               count;
      longint           x, y, z, rate, ty, tz;
      lorenz_point_type p;
      count = point_count;
      if (count < 1) count = 1;
      if (count > lei_pkg::MAX_POINTS_DEF) count = lei_pkg::MAX_POINTS_DEF;
      accepted++;
      if (restart) restarts++;
      else if (run_started && int'(cur_index) + 1 >= count) wraps++;
      if (restart || !run_started || int'(cur_index) + 1 >= count) begin
         cur_x = start_x;
         cur_y = start_y;
         cur_z = start_z;
         cur_index = '0;
         run_started = 1;
      end else begin
         x = cur_x;
         y = cur_y;
         z = cur_z;
         rate = qmul(step_size, sigma);
         cur_x = clamp32(x + qmul(rate, clamp32(y - x)));
         ty = clamp32(qmul(x, clamp32(rho - z)) - y);
         cur_y = clamp32(y + qmul(step_size, ty));
         tz = clamp32(qmul(x, y) - qmul(beta, z));
         cur_z = clamp32(z + qmul(step_size, tz));
         cur_index = cur_index + 16'd1;
      end
      p.pos_x = cur_x;
      p.pos_y = cur_y;
      p.pos_z = cur_z;
      p.point_index = cur_index;
      p.red = cur_index[7:0];
      p.green = cur_index[6:0];
      p.blue = cur_index[5:0];
      p.is_last = (int'(cur_index) + 1 == count);
      if (p.is_last) last_points++;
      expected_points.push_back(p);
   endfunction

   task report(string msg);
      errors++;
      $display("ERROR point %0d: %s", checked, msg);
   endtask

   task compare(string field, logic [31:0] got_v, logic [31:0] want_v);
      if (got_v !== want_v)
         report($sformatf("%s got %h, expected %h", field, got_v, want_v));
   endtask

   task check_point(lorenz_point_type got);
      lorenz_point_type want;
      checked++;
      if (expected_points.size() == 0) begin
         report($sformatf("response with no request pending, index %0d", got.point_index));
      end else begin
         want = expected_points.pop_front();
         compare("pos_x", got.pos_x, want.pos_x);
         compare("pos_y", got.pos_y, want.pos_y);
         compare("pos_z", got.pos_z, want.pos_z);
         compare("point_index", got.point_index, want.point_index);
         compare("color_red", got.red, want.red);
         compare("color_green", got.green, want.green);
         compare("color_blue", got.blue, want.blue);
         compare("is_last", got.is_last, want.is_last);
      end
   endtask
endclass

module tb_lorenz_euler_integrator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 900;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_OFF_CYCLES = 160;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct packed {
      logic [2:0]  idx;
      logic [31:0] value;
   } reg_write_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_en;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic               req_restart;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [15:0]        rsp_point_index;
   logic [7:0]         rsp_color_red;
   logic [6:0]         rsp_color_green;
   logic [5:0]         rsp_color_blue;
   logic               rsp_is_last;

   lorenz_tracker trajectory = new;
   reg_write_type reg_plan[$];
   bit            steady = 0;
   int            settings_used = 0;
   int            cycle_count;

   lorenz_euler_integrator uut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x),
      .rsp_pos_y(rsp_pos_y),
      .rsp_pos_z(rsp_pos_z),
      .rsp_point_index(rsp_point_index),
      .rsp_color_red(rsp_color_red),
      .rsp_color_green(rsp_color_green),
      .rsp_color_blue(rsp_color_blue),
      .rsp_is_last(rsp_is_last)
   );

   always #4 clock = ~clock;

   task automatic send_request(input bit restart);
      if (!steady && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      trajectory.note_request(restart);
   endtask

   task automatic stage_reg(input logic [2:0] idx, input logic [31:0] value);
      reg_plan.push_back('{idx, value});
   endtask

   task automatic apply_regs();
      foreach (reg_plan[i]) begin
         csr_write_en <= 1'b1;
         csr_index <= reg_plan[i].idx;
         csr_wdata <= reg_plan[i].value;
         @(posedge clock);
         trajectory.write_reg(reg_plan[i].idx, reg_plan[i].value);
      end
      csr_write_en <= 1'b0;
      @(posedge clock);
      reg_plan.delete();
      settings_used++;
   endtask

   // wait for every owed point, then let the sequencer go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (trajectory.expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_rail();
      case ($urandom_range(4))
         0: return lei_pkg::SAT_MAX;
         1: return lei_pkg::SAT_MIN;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return 32'h0001_0000;
      endcase
   endfunction

   // mostly near the usual value, sometimes anything, sometimes a rail
   function automatic logic [31:0] coeff(input int typical, input int spread);
      int r;
      r = $urandom_range(99);
      if (r < 65) return typical + int'($urandom_range(0, 2 * spread)) - spread;
      if (r < 88) return $urandom;
      return pick_rail();
   endfunction

   task automatic pick_random_setting();
      int          r;
      logic [31:0] cv;
      if ($urandom_range(99) < 60) stage_reg(lei_pkg::REG_SIGMA, coeff(10 << 16, 3 << 16));
      if ($urandom_range(99) < 60) stage_reg(lei_pkg::REG_RHO, coeff(28 << 16, 6 << 16));
      if ($urandom_range(99) < 60) stage_reg(lei_pkg::REG_BETA, coeff(174763, 40000));
      if ($urandom_range(99) < 60)
         stage_reg(lei_pkg::REG_STEP_SIZE, coeff(655, 500) | ($urandom_range(1) << 31));
      if ($urandom_range(99) < 60) stage_reg(lei_pkg::REG_START_X, coeff(0, 20 << 16));
      if ($urandom_range(99) < 60) stage_reg(lei_pkg::REG_START_Y, coeff(0, 20 << 16));
      if ($urandom_range(99) < 60) stage_reg(lei_pkg::REG_START_Z, coeff(0, 20 << 16));
      r = $urandom_range(99);
      if (r < 50) cv = $urandom_range(1, 40);
      else if (r < 70) cv = $urandom_range(41, 400);
      else if (r < 80) cv = 0;
      else if (r < 90) cv = $urandom_range(65537, 131071);
      else cv = $urandom_range(401, 65536);
      if ($urandom_range(99) < 70)
         stage_reg(lei_pkg::REG_POINT_COUNT, cv | ($urandom & 32'hFFFE_0000));
   endtask

   // receiver: random stalls plus one long hold-off once traffic is flowing
   initial begin
      int hold_left;
      bit held_off;
      hold_left = 0;
      held_off = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            trajectory.check_point({rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_point_index,
                                    rsp_color_red, rsp_color_green, rsp_color_blue,
                                    rsp_is_last});
         if (!held_off && trajectory.accepted >= 300) begin
            held_off = 1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && $urandom_range(99) < 21;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d points still owed", cycle_count,
               trajectory.expected_points.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int done, n, phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_restart = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first request after reset loads the start point even without restart
      send_request(0);
      send_request(0);
      send_request(0);
      send_request(1);
      send_request(0);
      settle();

      // bit 31 of the step and the upper bits of the count are dropped
      stage_reg(lei_pkg::REG_SIGMA, 10 << 16);
      stage_reg(lei_pkg::REG_RHO, 28 << 16);
      stage_reg(lei_pkg::REG_BETA, 174763);
      stage_reg(lei_pkg::REG_STEP_SIZE, 32'h8000_028F);
      stage_reg(lei_pkg::REG_START_X, 1 << 16);
      stage_reg(lei_pkg::REG_START_Y, 1 << 16);
      stage_reg(lei_pkg::REG_START_Z, 1 << 16);
      stage_reg(lei_pkg::REG_POINT_COUNT, 32'hFFFE_0003);
      apply_regs();
      repeat (4) send_request(0);
      settle();

      // zero count acts as one, counts past 65536 clamp
      stage_reg(lei_pkg::REG_POINT_COUNT, 0);
      apply_regs();
      repeat (2) send_request(0);
      settle();
      stage_reg(lei_pkg::REG_POINT_COUNT, 32'h0001_0001);
      apply_regs();
      repeat (2) send_request(0);
      settle();

      // sigma, rho, beta and the x and z starts driven into both rails, y and the step to the top
      stage_reg(lei_pkg::REG_SIGMA, lei_pkg::SAT_MAX);
      stage_reg(lei_pkg::REG_RHO, lei_pkg::SAT_MIN);
      stage_reg(lei_pkg::REG_BETA, lei_pkg::SAT_MAX);
      stage_reg(lei_pkg::REG_STEP_SIZE, 32'h7FFF_FFFF);
      stage_reg(lei_pkg::REG_START_X, lei_pkg::SAT_MIN);
      stage_reg(lei_pkg::REG_START_Y, lei_pkg::SAT_MAX);
      stage_reg(lei_pkg::REG_START_Z, lei_pkg::SAT_MIN);
      stage_reg(lei_pkg::REG_POINT_COUNT, 32'h0001_FFFF);
      apply_regs();
      send_request(1);
      repeat (3) send_request(0);
      settle();
      stage_reg(lei_pkg::REG_SIGMA, lei_pkg::SAT_MIN);
      stage_reg(lei_pkg::REG_RHO, lei_pkg::SAT_MAX);
      stage_reg(lei_pkg::REG_BETA, lei_pkg::SAT_MIN);
      stage_reg(lei_pkg::REG_STEP_SIZE, 32'h8000_0000);
      stage_reg(lei_pkg::REG_START_X, lei_pkg::SAT_MAX);
      stage_reg(lei_pkg::REG_START_Y, lei_pkg::SAT_MAX);
      stage_reg(lei_pkg::REG_START_Z, lei_pkg::SAT_MAX);
      apply_regs();
      send_request(1);
      repeat (2) send_request(0);
      settle();

      // count lowered below the running index: next advance wraps to the start
      stage_reg(lei_pkg::REG_SIGMA, 10 << 16);
      stage_reg(lei_pkg::REG_RHO, 28 << 16);
      stage_reg(lei_pkg::REG_BETA, 174763);
      stage_reg(lei_pkg::REG_STEP_SIZE, 655);
      stage_reg(lei_pkg::REG_START_X, 655);
      stage_reg(lei_pkg::REG_START_Y, 0);
      stage_reg(lei_pkg::REG_START_Z, 0);
      stage_reg(lei_pkg::REG_POINT_COUNT, 20);
      apply_regs();
      send_request(1);
      repeat (5) send_request(0);
      settle();
      stage_reg(lei_pkg::REG_POINT_COUNT, 3);
      apply_regs();
      send_request(0);
      settle();

      done = 0;
      phase = 0;
      while (done < RANDOM_ITEMS) begin
         pick_random_setting();
         apply_regs();
         steady = (phase == 2);
         n = $urandom_range(30, 90);
         repeat (n) send_request($urandom_range(99) < 4);
         done += n;
         phase++;
         settle();
      end
      steady = 0;

      $display("Covered %0d requests: %0d restarts, %0d wraps at end of run, %0d last points",
               trajectory.accepted, trajectory.restarts, trajectory.wraps,
               trajectory.last_points);
      $display("across %0d register settings (%0d writes) incl. rails and count clamping",
               settings_used, trajectory.reg_writes);
      if (trajectory.errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
